FILE: rtl/core/nfd_pkg.sv
package nfd_pkg;

    localparam int Q_W        = 32;
    localparam int FRAC_BITS  = 30;
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int POST_STAGES = 6;

    localparam int R_DEN_W = 63;
    localparam int G_DEN_W = 38;
    localparam int H_DEN_W = 32;

    localparam logic [31:0] INV_4MP2_Q32 = 32'd1219669815;
    localparam logic [31:0] ONE_Q24      = 32'h0100_0000;
    localparam logic [37:0] TEN_Q24      = 38'd167772160;

    localparam logic        [31:0] DIPOLE_MASS_RST    = 32'd226291089;
    localparam logic signed [31:0] PROTON_MOMENT_RST  = 32'sd749699265;
    localparam logic signed [31:0] NEUTRON_MOMENT_RST = -32'sd513528491;

    typedef enum logic [1:0] {
        REG_DIPOLE_MASS    = 2'd0,
        REG_PROTON_MOMENT  = 2'd1,
        REG_NEUTRON_MOMENT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic valid;
        logic dzero;
    } div_ctl_t;

endpackage

FILE: rtl/core/nfd_div.sv
module nfd_div #(
    parameter int W = 32
) (
    input  logic                            clk,
    input  logic [W-1:0]                    num,
    input  logic [W-1:0]                    den,
    output logic [nfd_pkg::FRAC_BITS:0]     quo
);

    localparam int STEPS = nfd_pkg::FRAC_BITS;
    localparam int QW    = STEPS + 1;

    logic [W-1:0]  rem_reg  [0:STEPS-1];
    logic [W-1:0]  den_reg  [0:STEPS-1];
    logic [QW-1:0] quo_reg  [0:STEPS];
    logic [W-1:0]  rem_next [0:STEPS-1];
    logic [QW-1:0] quo_next [0:STEPS];
    logic [W:0]    sh       [1:STEPS];

    always_comb
    begin
        // integer part is a single compare, numerator never reaches twice the divisor
        if (num >= den)
        begin
            rem_next[0] = num - den;
            quo_next[0] = QW'(1);
        end
        else
        begin
            rem_next[0] = num;
            quo_next[0] = '0;
        end
        for (int k = 1; k < STEPS; k++)
        begin
            sh[k] = {rem_reg[k-1], 1'b0};
            if (sh[k] >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = W'(sh[k] - {1'b0, den_reg[k-1]});
                quo_next[k] = {quo_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = W'(sh[k]);
                quo_next[k] = {quo_reg[k-1][QW-2:0], 1'b0};
            end
        end
        // last stage needs only the quotient bit
        sh[STEPS]       = {rem_reg[STEPS-1], 1'b0};
        quo_next[STEPS] = {quo_reg[STEPS-1][QW-2:0],
                           sh[STEPS] >= {1'b0, den_reg[STEPS-1]}};
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        for (int k = 0; k < STEPS; k++)
        begin
            rem_reg[k] <= rem_next[k];
        end
        for (int k = 0; k <= STEPS; k++)
        begin
            quo_reg[k] <= quo_next[k];
        end
        for (int k = 1; k < STEPS; k++)
        begin
            den_reg[k] <= den_reg[k-1];
        end
    end

    assign quo = quo_reg[STEPS];

endmodule

FILE: rtl/core/nfd_post.sv
module nfd_post (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nfd_pkg::div_ctl_t               ctl,
    input  logic [nfd_pkg::FRAC_BITS:0]     r_quo,
    input  logic [nfd_pkg::FRAC_BITS:0]     g_quo,
    input  logic [nfd_pkg::FRAC_BITS:0]     h_quo,
    input  logic signed [31:0]              mup,
    input  logic signed [31:0]              mun,
    output logic                            done,
    output logic signed [31:0]              proton_electric,
    output logic signed [31:0]              neutron_electric,
    output logic signed [31:0]              proton_magnetic,
    output logic signed [31:0]              neutron_magnetic,
    output logic signed [31:0]              proton_dirac,
    output logic signed [31:0]              neutron_dirac,
    output logic signed [31:0]              proton_pauli,
    output logic signed [31:0]              neutron_pauli,
    output logic                            saturated
);

    function automatic logic [32:0] clamp32(input logic signed [34:0] v);
        logic [32:0] res;
        if (v > 35'sd2147483647)
            res = {1'b1, 32'h7FFF_FFFF};
        else if (v < -35'sd2147483648)
            res = {1'b1, 32'h8000_0000};
        else
            res = {1'b0, v[31:0]};
        return res;
    endfunction

    logic [5:0] v_reg;

    // stage 1: dipole square
    logic [30:0] r_sel;
    logic [61:0] rr;
    logic [28:0] gd1_reg;
    logic [27:0] g1_reg;
    logic [30:0] h1_reg;

    // stage 2
    logic [56:0]        gp;
    logic signed [61:0] pmp;
    logic signed [61:0] pmn;
    logic [28:0]        gep2_reg;
    logic [26:0]        ggd2_reg;
    logic signed [31:0] gmp2_reg;
    logic signed [31:0] gmn2_reg;
    logic [30:0]        h2_reg;

    // stage 3
    logic signed [32:0] negmun;
    logic signed [60:0] pen;
    logic [28:0]        gep3_reg;
    logic signed [31:0] gen3_reg;
    logic signed [31:0] gmp3_reg;
    logic signed [31:0] gmn3_reg;
    logic [30:0]        h3_reg;

    // stage 4
    logic [28:0]        gep4_reg;
    logic signed [31:0] gen4_reg;
    logic signed [31:0] gmp4_reg;
    logic signed [31:0] gmn4_reg;
    logic signed [32:0] dp4_reg;
    logic signed [32:0] dn4_reg;
    logic [30:0]        h4_reg;

    // stage 5
    logic signed [64:0] pfp;
    logic signed [64:0] pfn;
    logic [28:0]        gep5_reg;
    logic signed [31:0] gen5_reg;
    logic signed [31:0] gmp5_reg;
    logic signed [31:0] gmn5_reg;
    logic signed [33:0] f2p5_reg;
    logic signed [33:0] f2n5_reg;

    // stage 6
    logic signed [34:0] f1p;
    logic signed [34:0] f1n;
    logic [32:0]        c1p;
    logic [32:0]        c1n;
    logic [32:0]        c2p;
    logic [32:0]        c2n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], ctl.valid};
    end

    always_comb
    begin
        r_sel  = ctl.dzero ? 31'h4000_0000 : r_quo;
        rr     = r_sel * r_sel;
        gp     = g1_reg * gd1_reg;
        pmp    = mup * $signed({1'b0, gd1_reg});
        pmn    = mun * $signed({1'b0, gd1_reg});
        negmun = -$signed({mun[31], mun});
        pen    = negmun * $signed({1'b0, ggd2_reg});
        pfp    = dp4_reg * $signed({1'b0, h4_reg});
        pfn    = dn4_reg * $signed({1'b0, h4_reg});
        f1p    = 35'(gmp5_reg) - 35'(f2p5_reg);
        f1n    = 35'(gmn5_reg) - 35'(f2n5_reg);
        c1p    = clamp32(f1p);
        c1n    = clamp32(f1n);
        c2p    = clamp32(35'(f2p5_reg));
        c2n    = clamp32(35'(f2n5_reg));
    end

    always_ff @(posedge clk)
    begin
        gd1_reg  <= rr[60:32];
        g1_reg   <= g_quo[27:0];
        h1_reg   <= h_quo;

        gep2_reg <= gd1_reg;
        ggd2_reg <= gp[56:30];
        gmp2_reg <= pmp[59:28];
        gmn2_reg <= pmn[59:28];
        h2_reg   <= h1_reg;

        gep3_reg <= gep2_reg;
        gen3_reg <= pen[59:28];
        gmp3_reg <= gmp2_reg;
        gmn3_reg <= gmn2_reg;
        h3_reg   <= h2_reg;

        gep4_reg <= gep3_reg;
        gen4_reg <= gen3_reg;
        gmp4_reg <= gmp3_reg;
        gmn4_reg <= gmn3_reg;
        dp4_reg  <= 33'(gmp3_reg) - $signed({4'b0, gep3_reg});
        dn4_reg  <= 33'(gmn3_reg) - 33'(gen3_reg);
        h4_reg   <= h3_reg;

        gep5_reg <= gep4_reg;
        gen5_reg <= gen4_reg;
        gmp5_reg <= gmp4_reg;
        gmn5_reg <= gmn4_reg;
        f2p5_reg <= pfp[63:30];
        f2n5_reg <= pfn[63:30];

        proton_electric  <= {3'b0, gep5_reg};
        neutron_electric <= gen5_reg;
        proton_magnetic  <= gmp5_reg;
        neutron_magnetic <= gmn5_reg;
        proton_dirac     <= c1p[31:0];
        neutron_dirac    <= c1n[31:0];
        proton_pauli     <= c2p[31:0];
        neutron_pauli    <= c2n[31:0];
        saturated        <= c1p[32] | c1n[32] | c2p[32] | c2n[32];
    end

    assign done = v_reg[5];

    // only the dirac and pauli words can be clamped
    sat_is_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |->
            proton_dirac == 32'h7FFF_FFFF || proton_dirac == 32'h8000_0000 ||
            neutron_dirac == 32'h7FFF_FFFF || neutron_dirac == 32'h8000_0000 ||
            proton_pauli == 32'h7FFF_FFFF || proton_pauli == 32'h8000_0000 ||
            neutron_pauli == 32'h7FFF_FFFF || neutron_pauli == 32'h8000_0000)
        else $error("saturated set without a clamped word");

endmodule

FILE: rtl/core/nucleon_dipole_form_factors.sv
// throughput: one word per cycle, busy is always low
// three 31-stage restoring dividers (one quotient bit per stage) set the depth
// rst_n clears the valid pipeline and loads the default dipole mass and moments
// results are shown for one cycle under done; the receiver cannot stall
module nucleon_dipole_form_factors (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        q_squared,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic               done,
    output logic signed [31:0] proton_electric,
    output logic signed [31:0] neutron_electric,
    output logic signed [31:0] proton_magnetic,
    output logic signed [31:0] neutron_magnetic,
    output logic signed [31:0] proton_dirac,
    output logic signed [31:0] neutron_dirac,
    output logic signed [31:0] proton_pauli,
    output logic signed [31:0] neutron_pauli,
    output logic               saturated
);

    localparam int DIV_STAGES = nfd_pkg::DIV_STAGES;
    localparam int LATENCY    = 2 + DIV_STAGES + nfd_pkg::POST_STAGES;

    logic [31:0]        dipole_mass_reg;
    logic signed [31:0] proton_moment_reg;
    logic signed [31:0] neutron_moment_reg;

    logic               accept;
    logic               v1_reg;
    logic               v2_reg;
    logic [31:0]        q1_reg;
    logic [63:0]        ll_reg;
    logic [63:0]        tq_reg;

    logic [62:0]        n_s2;
    logic [62:0]        d_s2;
    logic [30:0]        t_s2;
    logic [62:0]        rn_reg;
    logic [62:0]        rd_reg;
    logic [37:0]        gn_reg;
    logic [37:0]        gden_reg;
    logic [31:0]        hden_reg;
    logic               dz_reg;

    nfd_pkg::div_ctl_t  ctl_reg [0:DIV_STAGES-1];

    logic [nfd_pkg::FRAC_BITS:0] r_quo;
    logic [nfd_pkg::FRAC_BITS:0] g_quo;
    logic [nfd_pkg::FRAC_BITS:0] h_quo;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dipole_mass_reg    <= nfd_pkg::DIPOLE_MASS_RST;
            proton_moment_reg  <= nfd_pkg::PROTON_MOMENT_RST;
            neutron_moment_reg <= nfd_pkg::NEUTRON_MOMENT_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                nfd_pkg::REG_DIPOLE_MASS:    dipole_mass_reg    <= pwdata;
                nfd_pkg::REG_PROTON_MOMENT:  proton_moment_reg  <= pwdata;
                nfd_pkg::REG_NEUTRON_MOMENT: neutron_moment_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            nfd_pkg::REG_DIPOLE_MASS:    prdata = dipole_mass_reg;
            nfd_pkg::REG_PROTON_MOMENT:  prdata = proton_moment_reg;
            nfd_pkg::REG_NEUTRON_MOMENT: prdata = neutron_moment_reg;
            default:                     prdata = '0;
        endcase
    end

    // valid pipeline through the front and the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
                ctl_reg[k] <= '0;
        end
        else
        begin
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            ctl_reg[0] <= '{valid: v2_reg, dzero: dz_reg};
            for (int k = 1; k < DIV_STAGES; k++)
                ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    always_comb
    begin
        n_s2 = {1'b0, ll_reg[63:2]};
        d_s2 = n_s2 + {1'b0, q1_reg, 30'b0};
        t_s2 = tq_reg[62:32];
    end

    always_ff @(posedge clk)
    begin
        q1_reg   <= q_squared;
        ll_reg   <= dipole_mass_reg * dipole_mass_reg;
        tq_reg   <= q_squared * nfd_pkg::INV_4MP2_Q32;

        rn_reg   <= n_s2;
        rd_reg   <= d_s2;
        dz_reg   <= (d_s2 == '0);
        // 10t and 10*2^24 + 56t by shift and add
        gn_reg   <= {4'b0, t_s2, 3'b0} + {6'b0, t_s2, 1'b0};
        gden_reg <= nfd_pkg::TEN_Q24 + {1'b0, t_s2, 6'b0} - {4'b0, t_s2, 3'b0};
        hden_reg <= {1'b0, t_s2} + nfd_pkg::ONE_Q24;
    end

    nfd_div #(.W(nfd_pkg::R_DEN_W)) u_div_r (
        .clk (clk),
        .num (rn_reg),
        .den (rd_reg),
        .quo (r_quo)
    );

    nfd_div #(.W(nfd_pkg::G_DEN_W)) u_div_g (
        .clk (clk),
        .num (gn_reg),
        .den (gden_reg),
        .quo (g_quo)
    );

    nfd_div #(.W(nfd_pkg::H_DEN_W)) u_div_h (
        .clk (clk),
        .num (nfd_pkg::ONE_Q24),
        .den (hden_reg),
        .quo (h_quo)
    );

    nfd_post u_post (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl_reg[DIV_STAGES-1]),
        .r_quo            (r_quo),
        .g_quo            (g_quo),
        .h_quo            (h_quo),
        .mup              (proton_moment_reg),
        .mun              (neutron_moment_reg),
        .done             (done),
        .proton_electric  (proton_electric),
        .neutron_electric (neutron_electric),
        .proton_magnetic  (proton_magnetic),
        .neutron_magnetic (neutron_magnetic),
        .proton_dirac     (proton_dirac),
        .neutron_dirac    (neutron_dirac),
        .proton_pauli     (proton_pauli),
        .neutron_pauli    (neutron_pauli),
        .saturated        (saturated)
    );

    done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result word without an accepted word");

    // the dipole never exceeds one
    electric_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !proton_electric[31] && proton_electric <= 32'sh1000_0000)
        else $error("proton electric word out of unit range");

    zero_den_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[DIV_STAGES-1].valid && ctl_reg[DIV_STAGES-1].dzero
            |-> g_quo == '0)
        else $error("zero momentum transfer gave nonzero galster ratio");

endmodule
